### rtl/page_framebuffer_draw_engine_assert.svh
// Assertion macros shared by the draw engine
`ifndef PAGE_FRAMEBUFFER_DRAW_ENGINE_ASSERT_SVH
`define PAGE_FRAMEBUFFER_DRAW_ENGINE_ASSERT_SVH

// same-cycle implication
`define PFDE_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define PFDE_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/pfde_pkg.sv
`default_nettype none
package pfde_pkg;

    // screen geometry and store size
    localparam int SCREEN_WIDTH  = 128;
    localparam int SCREEN_HEIGHT = 64;
    localparam int PAGE_COUNT    = 8;
    localparam int STORE_DEPTH   = 1024;

    localparam int ADDR_W     = $clog2(STORE_DEPTH);
    localparam int DIFF_PAGES = (PAGE_COUNT < 8) ? PAGE_COUNT : 8;
    localparam int PG_W       = (DIFF_PAGES > 1) ? $clog2(DIFF_PAGES) : 1;
    localparam int XW         = $clog2(SCREEN_WIDTH + 1);
    localparam int YW         = $clog2(SCREEN_HEIGHT + 1);
    localparam int COL_W      = $clog2(SCREEN_WIDTH);
    localparam int IDX_W      = $clog2(SCREEN_WIDTH * 8 + STORE_DEPTH);

    // request codes
    localparam logic [2:0] REQ_CLEAR  = 3'd0;
    localparam logic [2:0] REQ_PIXEL  = 3'd1;
    localparam logic [2:0] REQ_HLINE  = 3'd2;
    localparam logic [2:0] REQ_RECT   = 3'd3;
    localparam logic [2:0] REQ_COMMIT = 3'd4;
    localparam logic [2:0] REQ_DIFF   = 3'd5;
    localparam logic [2:0] REQ_READ   = 3'd6;

    // controller -> datapath
    typedef struct packed {
        logic init_step;
        logic load;
        logic clr_step;
        logic wr_step;
        logic push;
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic [2:0] req;
        logic       empty;
        logic       lin_last;
        logic       walk_last;
        logic       out_full;
    } t_status;

endpackage
`default_nettype wire

### rtl/pfde_ctrl.sv
`default_nettype none
module pfde_ctrl (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_in_valid,
    output logic              o_in_ready,
    input  pfde_pkg::t_status i_st,
    output pfde_pkg::t_cmd    o_cmd
);

    typedef enum logic [6:0] {
        S_INIT  = 7'b0000001,
        S_IDLE  = 7'b0000010,
        S_START = 7'b0000100,
        S_RD    = 7'b0001000,
        S_WR    = 7'b0010000,
        S_CLR   = 7'b0100000,
        S_DONE  = 7'b1000000
    } t_state;

    t_state r_state, n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
        end else begin
            r_state <= n_state;
        end
    end

    // next state and commands
    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_INIT: begin
                o_cmd.init_step = 1'b1;
                if (i_st.lin_last) n_state = S_IDLE;
            end
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_START;
                end
            end
            S_START: begin
                unique case (i_st.req)
                    pfde_pkg::REQ_CLEAR: n_state = S_CLR;
                    pfde_pkg::REQ_PIXEL,
                    pfde_pkg::REQ_HLINE,
                    pfde_pkg::REQ_RECT:  n_state = i_st.empty ? S_DONE : S_RD;
                    pfde_pkg::REQ_COMMIT,
                    pfde_pkg::REQ_DIFF,
                    pfde_pkg::REQ_READ:  n_state = S_RD;
                    default:             n_state = S_DONE;
                endcase
            end
            S_RD: begin
                n_state = S_WR;
            end
            S_WR: begin
                o_cmd.wr_step = 1'b1;
                n_state = i_st.walk_last ? S_DONE : S_RD;
            end
            S_CLR: begin
                o_cmd.clr_step = 1'b1;
                if (i_st.lin_last) n_state = S_DONE;
            end
            S_DONE: begin
                if (!i_st.out_full) begin
                    o_cmd.push = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: n_state = S_INIT;
        endcase
    end

endmodule
`default_nettype wire

### rtl/pfde_datapath.sv
`default_nettype none
module pfde_datapath (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  pfde_pkg::t_cmd     i_cmd,
    output pfde_pkg::t_status  o_st,
    input  wire  [2:0]         i_req_type,
    input  wire  signed [15:0] i_pos_x,
    input  wire  signed [15:0] i_pos_y,
    input  wire  signed [15:0] i_span_w,
    input  wire  signed [15:0] i_span_h,
    input  wire                i_pixel_on,
    input  wire  [9:0]         i_byte_addr,
    output logic               o_out_valid,
    input  wire                i_out_ready,
    output logic [7:0]         o_page_mask,
    output logic [7:0]         o_read_data,
    output logic               o_done_res
);

    localparam logic signed [16:0] W17 = 17'(pfde_pkg::SCREEN_WIDTH);
    localparam logic signed [16:0] H17 = 17'(pfde_pkg::SCREEN_HEIGHT);

    // stores
    logic [7:0] draw_mem  [pfde_pkg::STORE_DEPTH];
    logic [7:0] shown_mem [pfde_pkg::STORE_DEPTH];

    logic [2:0]                    r_req;
    logic                          r_on;
    logic [9:0]                    r_byte_addr;
    logic                          r_empty;
    logic [pfde_pkg::XW-1:0]       r_x0, r_x1, r_px;
    logic [pfde_pkg::YW-1:0]       r_y1, r_py;
    logic [pfde_pkg::ADDR_W-1:0]   r_addr;
    logic [pfde_pkg::COL_W-1:0]    r_col;
    logic [pfde_pkg::PG_W-1:0]     r_page;
    logic [7:0]                    r_mask;
    logic [7:0]                    r_rd_byte;
    logic [7:0]                    r_draw_q, r_shown_q;
    logic                          r_out_valid;
    logic [7:0]                    r_page_mask, r_read_data;
    logic                          r_done_res;

    // clip the request extents
    logic               is_pix_in, one_row_in;
    logic signed [15:0] w_eff, h_eff;
    logic signed [16:0] xs, xe, ys, ye, x0c, x1c, y0c, y1c;
    always_comb begin
        is_pix_in  = (i_req_type == pfde_pkg::REQ_PIXEL);
        one_row_in = is_pix_in || (i_req_type == pfde_pkg::REQ_HLINE);
        w_eff = is_pix_in  ? 16'sd1 : i_span_w;
        h_eff = one_row_in ? 16'sd1 : i_span_h;
        xs  = {i_pos_x[15], i_pos_x};
        ys  = {i_pos_y[15], i_pos_y};
        xe  = xs + {w_eff[15], w_eff};
        ye  = ys + {h_eff[15], h_eff};
        x0c = (xs < 17'sd0) ? 17'sd0 : xs;
        y0c = (ys < 17'sd0) ? 17'sd0 : ys;
        x1c = (xe > W17) ? W17 : xe;
        y1c = (ye > H17) ? H17 : ye;
    end

    // current store index
    logic                          is_pix, is_diff;
    logic [pfde_pkg::IDX_W-1:0]    pix_idx, diff_idx, cur_idx;
    logic [pfde_pkg::ADDR_W-1:0]   mem_a;
    logic                          in_range;
    logic [7:0]                    bit_m, pix_new;
    always_comb begin
        is_pix  = (r_req == pfde_pkg::REQ_PIXEL) || (r_req == pfde_pkg::REQ_HLINE)
                  || (r_req == pfde_pkg::REQ_RECT);
        is_diff = (r_req == pfde_pkg::REQ_DIFF);
        pix_idx  = pfde_pkg::IDX_W'(r_px)
                 + pfde_pkg::IDX_W'(r_py >> 3) * pfde_pkg::IDX_W'(pfde_pkg::SCREEN_WIDTH);
        diff_idx = pfde_pkg::IDX_W'(r_col)
                 + pfde_pkg::IDX_W'(r_page) * pfde_pkg::IDX_W'(pfde_pkg::SCREEN_WIDTH);
        priority if (is_pix)                      cur_idx = pix_idx;
        else if (is_diff)                         cur_idx = diff_idx;
        else if (r_req == pfde_pkg::REQ_READ)     cur_idx = pfde_pkg::IDX_W'(r_byte_addr);
        else                                      cur_idx = pfde_pkg::IDX_W'(r_addr);
        in_range = (cur_idx < pfde_pkg::IDX_W'(pfde_pkg::STORE_DEPTH));
        mem_a    = cur_idx[pfde_pkg::ADDR_W-1:0];
        bit_m    = 8'd1 << r_py[2:0];
        priority if (r_req == pfde_pkg::REQ_RECT) pix_new = r_draw_q ^ bit_m;
        else if (r_on)                            pix_new = r_draw_q | bit_m;
        else                                      pix_new = r_draw_q & ~bit_m;
    end

    // draw store port
    always_ff @(posedge i_clk) begin
        if (i_cmd.init_step || i_cmd.clr_step) begin
            draw_mem[r_addr] <= 8'd0;
        end else if (i_cmd.wr_step && is_pix && in_range) begin
            draw_mem[mem_a] <= pix_new;
        end
        r_draw_q <= draw_mem[mem_a];
    end

    // shown store port
    always_ff @(posedge i_clk) begin
        if (i_cmd.init_step) begin
            shown_mem[r_addr] <= 8'd0;
        end else if (i_cmd.wr_step && r_req == pfde_pkg::REQ_COMMIT) begin
            shown_mem[r_addr] <= r_draw_q;
        end
        r_shown_q <= shown_mem[mem_a];
    end

    // walk counters
    logic px_end, py_end, col_end, page_end, lin_last;
    always_comb begin
        px_end   = (r_px == pfde_pkg::XW'(r_x1 - 1'b1));
        py_end   = (r_py == pfde_pkg::YW'(r_y1 - 1'b1));
        col_end  = (r_col == pfde_pkg::COL_W'(pfde_pkg::SCREEN_WIDTH - 1));
        page_end = (r_page == pfde_pkg::PG_W'(pfde_pkg::DIFF_PAGES - 1));
        lin_last = (r_addr == pfde_pkg::ADDR_W'(pfde_pkg::STORE_DEPTH - 1));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_addr <= '0;
        end else if (i_cmd.load) begin
            r_addr <= '0;
        end else if (i_cmd.init_step || i_cmd.clr_step
                     || (i_cmd.wr_step && r_req == pfde_pkg::REQ_COMMIT)) begin
            r_addr <= r_addr + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_req       <= i_req_type;
            r_on        <= i_pixel_on;
            r_byte_addr <= i_byte_addr;
            r_empty     <= (x0c >= x1c) || (y0c >= y1c);
            r_x0        <= x0c[pfde_pkg::XW-1:0];
            r_x1        <= x1c[pfde_pkg::XW-1:0];
            r_px        <= x0c[pfde_pkg::XW-1:0];
            r_y1        <= y1c[pfde_pkg::YW-1:0];
            r_py        <= y0c[pfde_pkg::YW-1:0];
            r_col       <= '0;
            r_page      <= '0;
            r_mask      <= 8'd0;
            r_rd_byte   <= 8'd0;
        end else if (i_cmd.wr_step) begin
            if (is_pix) begin
                if (px_end) begin
                    r_px <= r_x0;
                    r_py <= r_py + 1'b1;
                end else begin
                    r_px <= r_px + 1'b1;
                end
            end
            if (is_diff) begin
                if (in_range && (r_draw_q != r_shown_q)) r_mask[r_page] <= 1'b1;
                if (col_end) begin
                    r_col  <= '0;
                    r_page <= r_page + 1'b1;
                end else begin
                    r_col <= r_col + 1'b1;
                end
            end
            if (r_req == pfde_pkg::REQ_READ) r_rd_byte <= r_shown_q;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.push) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.push) begin
            r_page_mask <= is_diff ? r_mask : 8'd0;
            r_read_data <= (r_req == pfde_pkg::REQ_READ) ? r_rd_byte : 8'd0;
            r_done_res  <= (r_req <= pfde_pkg::REQ_READ);
        end
    end

    // status back to the controller
    always_comb begin
        o_st.req      = r_req;
        o_st.empty    = r_empty;
        o_st.lin_last = lin_last;
        o_st.out_full = r_out_valid && !i_out_ready;
        priority if (is_pix)                        o_st.walk_last = px_end && py_end;
        else if (is_diff)                           o_st.walk_last = col_end && page_end;
        else if (r_req == pfde_pkg::REQ_COMMIT)     o_st.walk_last = lin_last;
        else                                        o_st.walk_last = 1'b1;
    end

    assign o_out_valid = r_out_valid;
    assign o_page_mask = r_page_mask;
    assign o_read_data = r_read_data;
    assign o_done_res  = r_done_res;

endmodule
`default_nettype wire

### rtl/page_framebuffer_draw_engine.sv
// Channel  | Handshake                 | Payload
// ---------+---------------------------+-----------------------------------------------
// request  | i_in_valid / o_in_ready   | i_req_type i_pos_x i_pos_y i_span_w i_span_h
//          |                           | i_pixel_on i_byte_addr
// result   | o_out_valid / i_out_ready | o_page_mask o_read_data o_done_res
//
// One request at a time. A pass after reset zeroes both stores; no request is
// taken until it ends. Clear zeroes the draw store, commit copies it to shown,
// diff compares pages, read fetches a byte, pixel/line/rect read-modify-write
// each clipped pixel on the single store port. The output register holds a
// result while the next request is taken; a stalled result blocks only the next.
`default_nettype none
module page_framebuffer_draw_engine (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_in_valid,
    output logic               o_in_ready,
    input  wire  [2:0]         i_req_type,
    input  wire  signed [15:0] i_pos_x,
    input  wire  signed [15:0] i_pos_y,
    input  wire  signed [15:0] i_span_w,
    input  wire  signed [15:0] i_span_h,
    input  wire                i_pixel_on,
    input  wire  [9:0]         i_byte_addr,
    output logic               o_out_valid,
    input  wire                i_out_ready,
    output logic [7:0]         o_page_mask,
    output logic [7:0]         o_read_data,
    output logic               o_done_res
);

    pfde_pkg::t_cmd    cmd;
    pfde_pkg::t_status st;

    pfde_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_st       (st),
        .o_cmd      (cmd)
    );

    pfde_datapath u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_st        (st),
        .i_req_type  (i_req_type),
        .i_pos_x     (i_pos_x),
        .i_pos_y     (i_pos_y),
        .i_span_w    (i_span_w),
        .i_span_h    (i_span_h),
        .i_pixel_on  (i_pixel_on),
        .i_byte_addr (i_byte_addr),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_page_mask (o_page_mask),
        .o_read_data (o_read_data),
        .o_done_res  (o_done_res)
    );

`include "page_framebuffer_draw_engine_assert.svh"

    `PFDE_ASSERT_NXT(a_busy_after_take, i_in_valid && o_in_ready, !o_in_ready, "ready after take")
    `PFDE_ASSERT_IMP(a_push_free, cmd.push, !(o_out_valid && !i_out_ready), "push into full")
    `PFDE_ASSERT_IMP(a_undef_zero, o_out_valid && !o_done_res,
                     (o_page_mask | o_read_data) == 8'd0, "undefined request result not zero")

endmodule
`default_nettype wire

### test/tb_page_framebuffer_draw_engine.sv
module tb_page_framebuffer_draw_engine;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [2:0] REQ_UNDEF = 3'd7;
    localparam int CYCLE_LIMIT = 12000000;
    localparam int RANDOM_ITEMS = 580;
    localparam int RX_HOLDOFF = 3000;

    typedef struct {
        logic [2:0]         req_type;
        logic signed [15:0] pos_x;
        logic signed [15:0] pos_y;
        logic signed [15:0] span_w;
        logic signed [15:0] span_h;
        logic               pixel_on;
        logic [9:0]         byte_addr;
        bit                 wait_drain;
    } t_request;

    typedef struct {
        logic [7:0] page_mask;
        logic [7:0] read_data;
        logic       done_res;
    } t_result;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_in_valid = 1'b0;
    logic               o_in_ready;
    logic [2:0]         i_req_type = '0;
    logic signed [15:0] i_pos_x = '0;
    logic signed [15:0] i_pos_y = '0;
    logic signed [15:0] i_span_w = '0;
    logic signed [15:0] i_span_h = '0;
    logic               i_pixel_on = 1'b0;
    logic [9:0]         i_byte_addr = '0;
    logic               o_out_valid;
    logic               i_out_ready = 1'b0;
    logic [7:0]         o_page_mask;
    logic [7:0]         o_read_data;
    logic               o_done_res;

    page_framebuffer_draw_engine i_dut (.*);

    // model copies of both stores
    logic [7:0] draw_mem [pfde_pkg::STORE_DEPTH];
    logic [7:0] shown_mem [pfde_pkg::STORE_DEPTH];

    t_request request_q[$];
    t_result  result_q[$];
    int       n_errors = 0;
    int       cycle = 0;
    int       n_results = 0;
    int       n_total = 0;

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // idle length: mostly none or short, sometimes long
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // stretches with no idling on either side
    function automatic bit no_idle();
        return cycle[12:10] == 3'd0;
    endfunction

    // mode 0 clears, 1 sets, 2 toggles
    task automatic touch_pixel(input int x, input int y, input int mode);
        int idx;
        logic [7:0] bitm;
        if (x < 0 || y < 0 || x >= pfde_pkg::SCREEN_WIDTH || y >= pfde_pkg::SCREEN_HEIGHT)
            return;
        idx = x + (y / 8) * pfde_pkg::SCREEN_WIDTH;
        if (idx >= pfde_pkg::STORE_DEPTH) return;
        bitm = 8'd1 << (y & 7);
        if (mode == 2) draw_mem[idx] ^= bitm;
        else if (mode == 1) draw_mem[idx] |= bitm;
        else draw_mem[idx] &= ~bitm;
    endtask

    task automatic walk_area(input int x, input int y, input int w, input int h,
                             input int mode);
        int x0, x1, y0, y1;
        if (w <= 0 || h <= 0) return;
        x0 = (x < 0) ? 0 : x;
        y0 = (y < 0) ? 0 : y;
        x1 = (x + w > pfde_pkg::SCREEN_WIDTH) ? pfde_pkg::SCREEN_WIDTH : x + w;
        y1 = (y + h > pfde_pkg::SCREEN_HEIGHT) ? pfde_pkg::SCREEN_HEIGHT : y + h;
        for (int py = y0; py < y1; py++)
            for (int px = x0; px < x1; px++)
                touch_pixel(px, py, mode);
    endtask

    // apply one request to the model stores and queue its result
    task automatic predict_request(input t_request rq);
        t_result rs;
        int idx;
        rs = '{8'd0, 8'd0, 1'b1};
        case (rq.req_type)
            pfde_pkg::REQ_CLEAR: foreach (draw_mem[i]) draw_mem[i] = '0;
            pfde_pkg::REQ_PIXEL:
                touch_pixel(int'(rq.pos_x), int'(rq.pos_y), int'(rq.pixel_on));
            pfde_pkg::REQ_HLINE:
                walk_area(int'(rq.pos_x), int'(rq.pos_y), int'(rq.span_w), 1,
                          int'(rq.pixel_on));
            pfde_pkg::REQ_RECT:
                walk_area(int'(rq.pos_x), int'(rq.pos_y), int'(rq.span_w),
                          int'(rq.span_h), 2);
            pfde_pkg::REQ_COMMIT: foreach (shown_mem[i]) shown_mem[i] = draw_mem[i];
            pfde_pkg::REQ_DIFF: begin
                for (int pg = 0; pg < pfde_pkg::PAGE_COUNT && pg < 8; pg++)
                    for (int c = 0; c < pfde_pkg::SCREEN_WIDTH; c++) begin
                        idx = pg * pfde_pkg::SCREEN_WIDTH + c;
                        if (idx < pfde_pkg::STORE_DEPTH && draw_mem[idx] != shown_mem[idx])
                            rs.page_mask[pg] = 1'b1;
                    end
            end
            pfde_pkg::REQ_READ: rs.read_data = shown_mem[rq.byte_addr];
            default: rs.done_res = 1'b0;
        endcase
        result_q.push_back(rs);
    endtask

    function automatic t_request mk(input logic [2:0] t, input int x, input int y,
                                    input int w, input int h, input bit on,
                                    input int addr);
        t_request rq;
        rq.req_type = t;
        rq.pos_x = 16'(x);
        rq.pos_y = 16'(y);
        rq.span_w = 16'(w);
        rq.span_h = 16'(h);
        rq.pixel_on = on;
        rq.byte_addr = 10'(addr);
        rq.wait_drain = 0;
        return rq;
    endfunction

    function automatic t_request random_request();
        t_request rq;
        int r;
        r = $urandom_range(0, 99);
        rq = mk(pfde_pkg::REQ_PIXEL, $urandom_range(0, 135) - 4, $urandom_range(0, 71) - 4,
                $urandom_range(0, 9) - 1, $urandom_range(0, 9) - 1,
                1'($urandom_range(0, 1)), $urandom_range(0, 1023));
        if (r < 4) rq.req_type = pfde_pkg::REQ_CLEAR;
        else if (r < 28) rq.req_type = pfde_pkg::REQ_PIXEL;
        else if (r < 48) begin
            rq.req_type = pfde_pkg::REQ_HLINE;
            rq.span_w = 16'($urandom_range(0, 40) - 2);
        end else if (r < 64) rq.req_type = pfde_pkg::REQ_RECT;
        else if (r < 71) rq.req_type = pfde_pkg::REQ_COMMIT;
        else if (r < 78) rq.req_type = pfde_pkg::REQ_DIFF;
        else if (r < 95) rq.req_type = pfde_pkg::REQ_READ;
        else rq.req_type = 3'($urandom_range(0, 7));
        // noise: arbitrary 16-bit geometry
        if ($urandom_range(0, 99) < 12) begin
            rq.pos_x = 16'($urandom);
            rq.pos_y = 16'($urandom);
            rq.span_w = 16'($urandom);
            rq.span_h = 16'($urandom);
        end
        // rare large rectangle
        if (rq.req_type == pfde_pkg::REQ_RECT && $urandom_range(0, 49) == 0) begin
            rq.span_w = 16'($urandom_range(60, 140));
            rq.span_h = 16'($urandom_range(30, 70));
        end
        // bound the cost of wide geometry
        if (rq.req_type == pfde_pkg::REQ_RECT && rq.span_w > 16 && rq.span_h > 16)
            rq.span_h = 16'sd3;
        return rq;
    endfunction

    // request driver
    int     tx_idle = 0;
    t_request cur;
    always @(posedge i_clk) begin
        bit busy;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            busy = i_in_valid;
            if (i_in_valid && o_in_ready) begin
                predict_request(cur);
                busy = 0;
                tx_idle = no_idle() ? 0 : idle_len();
            end
            if (!busy) begin
                if (tx_idle > 0) tx_idle--;
                else if (request_q.size() > 0 &&
                         !(request_q[0].wait_drain && result_q.size() > 0)) begin
                    cur = request_q.pop_front();
                    busy = 1;
                    i_req_type  <= cur.req_type;
                    i_pos_x     <= cur.pos_x;
                    i_pos_y     <= cur.pos_y;
                    i_span_w    <= cur.span_w;
                    i_span_h    <= cur.span_h;
                    i_pixel_on  <= cur.pixel_on;
                    i_byte_addr <= cur.byte_addr;
                end
            end
            i_in_valid <= busy;
        end
    end

    // result monitor and receiver stalls
    int rx_idle = 0;
    int rx_holdoff = 0;
    always @(posedge i_clk) begin
        t_result ex;
        bit rdy;
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) begin
                if (result_q.size() == 0) begin
                    $display("%0t: unexpected result mask=%h data=%h done=%b", $realtime,
                             o_page_mask, o_read_data, o_done_res);
                    n_errors++;
                end else begin
                    ex = result_q.pop_front();
                    if (o_page_mask !== ex.page_mask) begin
                        $display("%0t: page_mask expected %h actual %h", $realtime,
                                 ex.page_mask, o_page_mask);
                        n_errors++;
                    end
                    if (o_read_data !== ex.read_data) begin
                        $display("%0t: read_data expected %h actual %h", $realtime,
                                 ex.read_data, o_read_data);
                        n_errors++;
                    end
                    if (o_done_res !== ex.done_res) begin
                        $display("%0t: done_res expected %b actual %b", $realtime,
                                 ex.done_res, o_done_res);
                        n_errors++;
                    end
                end
                n_results++;
                if (n_results == 120) rx_holdoff = RX_HOLDOFF;
                rx_idle = no_idle() ? 0 : idle_len();
            end
            if (rx_holdoff > 0) begin
                rx_holdoff--;
                rdy = 0;
            end else if (rx_idle > 0) begin
                rx_idle--;
                rdy = 0;
            end else begin
                rdy = 1;
            end
            i_out_ready <= rdy;
        end
    end

    // cycle limit
    always @(posedge i_clk) begin
        cycle++;
        if (cycle >= CYCLE_LIMIT) begin
            $display("tb_page_framebuffer_draw_engine: errors");
            $finish;
        end
    end

    initial begin
        t_request rq;
        foreach (draw_mem[i]) begin
            draw_mem[i] = '0;
            shown_mem[i] = '0;
        end
        // directed: extremes and special cases
        request_q.push_back(mk(pfde_pkg::REQ_READ, 0, 0, 0, 0, 0, 0));
        request_q.push_back(mk(pfde_pkg::REQ_PIXEL, 0, 0, 0, 0, 1, 0));
        request_q.push_back(mk(pfde_pkg::REQ_PIXEL, 127, 63, 0, 0, 1, 0));
        request_q.push_back(mk(pfde_pkg::REQ_PIXEL, -1, 0, 0, 0, 1, 0));
        request_q.push_back(mk(pfde_pkg::REQ_PIXEL, 128, 5, 0, 0, 1, 0));
        request_q.push_back(mk(pfde_pkg::REQ_PIXEL, 3, 64, 0, 0, 1, 0));
        request_q.push_back(mk(pfde_pkg::REQ_PIXEL, -32768, 32767, 0, 0, 1, 1023));
        request_q.push_back(mk(pfde_pkg::REQ_PIXEL, 0, 0, 0, 0, 0, 0));
        request_q.push_back(mk(pfde_pkg::REQ_HLINE, 10, 10, 0, 0, 1, 0));
        request_q.push_back(mk(pfde_pkg::REQ_HLINE, 10, 11, -32768, 0, 1, 0));
        request_q.push_back(mk(pfde_pkg::REQ_HLINE, -5, 12, 20, 0, 1, 0));
        request_q.push_back(mk(pfde_pkg::REQ_HLINE, 120, 13, 32767, 0, 1, 0));
        request_q.push_back(mk(pfde_pkg::REQ_HLINE, 32767, 14, 32767, 0, 1, 0));
        request_q.push_back(mk(pfde_pkg::REQ_RECT, 5, 5, 4, 0, 0, 0));
        request_q.push_back(mk(pfde_pkg::REQ_RECT, 5, 5, -32768, 32767, 0, 0));
        request_q.push_back(mk(pfde_pkg::REQ_RECT, -3, -2, 10, 12, 0, 0));
        request_q.push_back(mk(pfde_pkg::REQ_DIFF, 0, 0, 0, 0, 0, 0));
        request_q.push_back(mk(pfde_pkg::REQ_COMMIT, 0, 0, 0, 0, 0, 0));
        request_q.push_back(mk(pfde_pkg::REQ_DIFF, 0, 0, 0, 0, 0, 0));
        request_q.push_back(mk(pfde_pkg::REQ_READ, 0, 0, 0, 0, 0, 1023));
        request_q.push_back(mk(pfde_pkg::REQ_READ, 0, 0, 0, 0, 0, 127));
        request_q.push_back(mk(pfde_pkg::REQ_RECT, -32768, -32768, 32767, 32767, 0, 0));
        request_q.push_back(mk(pfde_pkg::REQ_DIFF, 0, 0, 0, 0, 0, 0));
        request_q.push_back(mk(REQ_UNDEF, -1, -1, -1, -1, 1, 1023));
        rq = mk(pfde_pkg::REQ_CLEAR, 0, 0, 0, 0, 0, 0);
        rq.wait_drain = 1;
        request_q.push_back(rq);
        // random: mostly on-screen drawing with occasional drain pauses
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            rq = random_request();
            if (n % 150 == 149) rq.wait_drain = 1;
            request_q.push_back(rq);
        end
        n_total = request_q.size();

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // every request gives exactly one result
        wait (n_results >= n_total);
        repeat (50) @(posedge i_clk);
        if (n_errors == 0 && result_q.size() == 0 && n_results == n_total)
            $display("tb_page_framebuffer_draw_engine: clean");
        else
            $display("tb_page_framebuffer_draw_engine: errors");
        $finish;
    end
endmodule
